[sv/mh64bs_pkg.sv]
// ============================================================================
// mh64bs_pkg
// Shared types, constants and byte helpers for the MurmurHash64B block.
// ============================================================================
package mh64bs_pkg;

  // Hash constants
  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;
  localparam int unsigned FIN_SH1    = 18;
  localparam int unsigned FIN_SH2    = 22;
  localparam int unsigned FIN_SH3    = 17;
  localparam int unsigned FIN_SH4    = 19;

  // Byte scrambler constants
  localparam logic [7:0] SCR_XOR = 8'hFF;
  localparam logic [7:0] SCR_ADD = 8'h20;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 96;

  // Configuration register indexes
  localparam logic REG_HASH_SEED = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_KEY1,
    OP_KEY2,
    OP_LANE,
    OP_TAIL,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3,
    OP_FIN4,
    OP_EMIT
  } dp_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY1,
    ST_KEY2,
    ST_LANE,
    ST_TAIL,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_full;   // incoming item holds a full word
    logic new_tail;   // incoming item holds 1-3 bytes
    logic new_last;   // incoming item ends a message
    logic item_last;  // latched item ends a message
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

  // ((b ^ 0xFF) + 0x20) mod 256
  function automatic logic [7:0] scramble_byte(input logic [7:0] b);
    scramble_byte = (b ^ SCR_XOR) + SCR_ADD;
  endfunction

  // ((b - 0x20) mod 256) ^ 0xFF
  function automatic logic [7:0] unscramble_byte(input logic [7:0] b);
    unscramble_byte = (b - SCR_ADD) ^ SCR_XOR;
  endfunction

endpackage

[sv/mh64bs_ctrl.sv]
// ============================================================================
// mh64bs_ctrl
// Sequencer: issues one datapath op per cycle for an item; emit may wait.
// ============================================================================
module mh64bs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mh64bs_pkg::dp_stat_t stat,
  output mh64bs_pkg::dp_cmd_t  cmd
);
  import mh64bs_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_LOAD;
          if (stat.new_full) begin
            state_nxt = ST_KEY1;
          end else if (stat.new_tail) begin
            state_nxt = ST_TAIL;
          end else if (stat.new_last) begin
            state_nxt = ST_FIN1;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_KEY1: begin
        cmd.op    = OP_KEY1;
        state_nxt = ST_KEY2;
      end
      ST_KEY2: begin
        cmd.op    = OP_KEY2;
        state_nxt = ST_LANE;
      end
      ST_LANE: begin
        cmd.op    = OP_LANE;
        state_nxt = stat.item_last ? ST_FIN1 : ST_EMIT;
      end
      ST_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = stat.item_last ? ST_FIN1 : ST_EMIT;
      end
      ST_FIN1: begin
        cmd.op    = OP_FIN1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op    = OP_FIN2;
        state_nxt = ST_FIN3;
      end
      ST_FIN3: begin
        cmd.op    = OP_FIN3;
        state_nxt = ST_FIN4;
      end
      ST_FIN4: begin
        cmd.op    = OP_FIN4;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/mh64bs_dp.sv]
// ============================================================================
// mh64bs_dp
// Datapath: byte scrambler, lane accumulators, shared constant multiplier,
// configuration registers and output register.
// ============================================================================
module mh64bs_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // configuration
  input  logic                                     cfg_we,
  input  logic                                     cfg_index,
  input  logic [31:0]                              cfg_data,
  // input payload
  input  logic [mh64bs_pkg::IN_TDATA_W-1:0]        in_tdata,
  input  logic                                     in_tlast,
  input  logic                                     in_tuser,
  // output channel
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [mh64bs_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                     out_tlast,
  output logic                                     out_tuser,
  // control
  input  mh64bs_pkg::dp_cmd_t                      cmd,
  output mh64bs_pkg::dp_stat_t                     stat
);
  import mh64bs_pkg::*;

  // Input field unpacking
  logic [31:0] in_word;
  logic [2:0]  in_count;
  logic [31:0] in_len;
  logic [63:0] in_expected;
  logic [2:0]  cnt_eff;

  assign in_word     = in_tdata[31:0];
  assign in_count    = in_tdata[34:32];
  assign in_len      = in_tdata[66:35];
  assign in_expected = in_tdata[130:67];
  assign cnt_eff     = in_count[2] ? 3'd4 : in_count;

  // Registers
  logic [31:0] seed_r, seed_nxt;
  logic        dir_r, dir_nxt;
  logic [31:0] h1_r, h1_nxt;
  logic [31:0] h2_r, h2_nxt;
  logic        sel_r, sel_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] plain_r, plain_nxt;
  logic [31:0] scr_r, scr_nxt;
  logic        last_r, last_nxt;
  logic [63:0] exp_r, exp_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [63:0] oh_r, oh_nxt;
  logic        od_r, od_nxt;
  logic        om_r, om_nxt;

  // Byte scramble / unscramble of the incoming word
  logic [31:0] plain_in;
  logic [31:0] scr_in;
  always_comb begin
    logic [7:0] b;
    logic [7:0] p;
    logic [7:0] o;
    plain_in = '0;
    scr_in   = '0;
    for (int i = 0; i < 4; i++) begin
      b = in_word[8*i +: 8];
      if (dir_r == DIR_DECODE) begin
        p = unscramble_byte(b);
        o = p;
      end else begin
        p = b;
        o = scramble_byte(b);
      end
      if (3'(i) < cnt_eff) begin
        plain_in[8*i +: 8] = p;
        scr_in[8*i +: 8]   = o;
      end
    end
  end

  // Shared multiplier by the mix constant, low 32 bits
  logic [31:0] mul_in;
  logic [31:0] mul_out;
  always_comb begin
    case (cmd.op)
      OP_KEY1: mul_in = plain_r;
      OP_KEY2: mul_in = key_r ^ (key_r >> MIX_SHIFT);
      OP_LANE: mul_in = sel_r ? h2_r : h1_r;
      OP_TAIL: mul_in = h2_r ^ plain_r;
      OP_FIN1: mul_in = h1_r ^ (h2_r >> FIN_SH1);
      OP_FIN2: mul_in = h2_r ^ (h1_r >> FIN_SH2);
      OP_FIN3: mul_in = h1_r ^ (h2_r >> FIN_SH3);
      OP_FIN4: mul_in = h2_r ^ (h1_r >> FIN_SH4);
      default: mul_in = plain_r;
    endcase
  end
  assign mul_out = mul_in * MIX_MUL;

  // Next-state logic
  always_comb begin
    seed_nxt  = seed_r;
    dir_nxt   = dir_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    sel_nxt   = sel_r;
    key_nxt   = key_r;
    plain_nxt = plain_r;
    scr_nxt   = scr_r;
    last_nxt  = last_r;
    exp_nxt   = exp_r;
    ov_nxt    = ov_r & ~out_tready;
    ow_nxt    = ow_r;
    oh_nxt    = oh_r;
    od_nxt    = od_r;
    om_nxt    = om_r;

    // config writes
    if (cfg_we) begin
      case (cfg_index)
        REG_HASH_SEED: seed_nxt = cfg_data;
        REG_DIRECTION: dir_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        plain_nxt = plain_in;
        scr_nxt   = scr_in;
        last_nxt  = in_tlast;
        exp_nxt   = in_expected;
        if (in_tuser) begin
          h1_nxt  = seed_r ^ in_len;
          h2_nxt  = '0;
          sel_nxt = 1'b0;
        end
      end
      OP_KEY1, OP_KEY2: key_nxt = mul_out;
      OP_LANE: begin
        if (sel_r) begin
          h2_nxt = mul_out ^ key_r;
        end else begin
          h1_nxt = mul_out ^ key_r;
        end
        sel_nxt = ~sel_r;
      end
      OP_TAIL, OP_FIN2, OP_FIN4: h2_nxt = mul_out;
      OP_FIN1, OP_FIN3:          h1_nxt = mul_out;
      OP_EMIT: begin
        ov_nxt = 1'b1;
        ow_nxt = scr_r;
        od_nxt = last_r;
        oh_nxt = last_r ? {h1_r, h2_r} : 64'd0;
        om_nxt = last_r && (dir_r == DIR_DECODE) && ({h1_r, h2_r} == exp_r);
      end
      default: ;
    endcase
  end

  // Control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
      dir_r  <= DIR_ENCODE;
      h1_r   <= '0;
      h2_r   <= '0;
      sel_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      seed_r <= seed_nxt;
      dir_r  <= dir_nxt;
      h1_r   <= h1_nxt;
      h2_r   <= h2_nxt;
      sel_r  <= sel_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    plain_r <= plain_nxt;
    scr_r   <= scr_nxt;
    last_r  <= last_nxt;
    exp_r   <= exp_nxt;
    ow_r    <= ow_nxt;
    oh_r    <= oh_nxt;
    od_r    <= od_nxt;
    om_r    <= om_nxt;
  end

  // Status to controller
  assign stat.new_full  = (cnt_eff == 3'd4);
  assign stat.new_tail  = (cnt_eff != 3'd0) && (cnt_eff != 3'd4);
  assign stat.new_last  = in_tlast;
  assign stat.item_last = last_r;
  assign stat.out_free  = ~ov_r | out_tready;

  // Output channel
  assign out_tvalid = ov_r;
  assign out_tdata  = {oh_r, ow_r};
  assign out_tlast  = od_r;
  assign out_tuser  = om_r;

endmodule

[sv/murmur64b_hash_with_byte_scramble.sv]
// ============================================================================
// murmur64b_hash_with_byte_scramble
// Streaming MurmurHash64B over little-endian words with a byte scrambler.
// ============================================================================
// Usage:
//   Input stream carries one message word per item; in_tuser marks the first
//   item of a message (lane 1 restarts from seed ^ length, lane 2 from zero),
//   in_tlast the final item (runs the finalizer). Each item gives exactly one output item: the
//   scrambled (encode) or unscrambled (decode) bytes, plus on the last item
//   the 64-bit hash and, in decode mode, a match flag against the expected
//   hash.
//   Timing: one 32-bit constant multiplier is shared and does one step per
//   cycle. A full word goes from accept to output load through accept, two
//   key-mix steps, lane update and emit; a 1-3 byte tail through accept,
//   tail mix and emit; an empty item through accept and emit. A last item
//   adds the finalizer mix steps before emit. One item is in work at a time.
//   The output register holds a finished result while the next item is
//   accepted and worked on; if the receiver stalls, the block waits before
//   emitting the following result.
//   Reset (synchronous, active low) clears both lanes, the lane select and
//   the output valid, and loads the seed register with its default.
//   Configuration writes are taken at any cycle; change them only when idle.
// ============================================================================
module murmur64b_hash_with_byte_scramble (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: index 0 hash_seed, index 1 direction
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [31:0]                          cfg_data,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [31:0] data_word, [34:32] byte_count, [66:35] message_length,
  // [130:67] expected_hash, [135:131] zero
  input  logic [mh64bs_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                 in_tlast,   // last_word
  input  logic                                 in_tuser,   // first_word
  // output stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] out_word, [95:32] hash_value
  output logic [mh64bs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                 out_tlast,  // hash_done
  output logic                                 out_tuser   // hash_match
);
  import mh64bs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mh64bs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mh64bs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  // One item in work at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while previous item still in work");

  // Match flag only on a finished hash
  a_match_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("hash_match without hash_done");

  // Hash field is zero on items that do not end a message
  a_hash_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[95:32] == 64'd0))
    else $error("nonzero hash_value on non-final item");

endmodule
